/* hw/rtl/skc_pkg.sv */
// shared types and constants for the subtractive keystream xor cipher
// no dependencies; imported by the stream interface users and all rtl modules

package skc_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned ADDR_W          = 6;
  localparam int unsigned POS_W           = 6;
  localparam int unsigned TABLE_LEN       = 55;
  localparam int unsigned POS_EMPTY       = 56;
  localparam int unsigned FILL_STEP       = 'h15;
  localparam int unsigned FILL_END        = 'h46E;
  localparam int unsigned FILL_STEPS      = FILL_END / FILL_STEP;
  localparam int unsigned MIX_LOW_COUNT   = 'h18;
  localparam int unsigned MIX_LOW_OFFSET  = 'h1F;
  localparam int unsigned MIX_HIGH_OFFSET = 'h18;
  localparam int unsigned MIX_PASSES      = 4;

  localparam logic MODE_REKEY = 1'b0;
  localparam logic MODE_CRYPT = 1'b1;

  typedef enum logic {
    ALU_SUB,
    ALU_XOR
  } alu_op_t;

  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] word;
    logic              last_word;
  } cmd_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic              out_last;
  } rsp_item_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } tab_req_t;

endpackage

/* hw/rtl/skc_stream_if.sv */
// valid/ready stream channel carrying one payload word per handshake
// payload type is set per instance, normally from skc_pkg

interface skc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* hw/rtl/skc_table.sv */
// 55 x 32 key table: one write port, two read ports with registered read data
// depends on skc_pkg

module skc_table (
  input  logic                         clk,
  input  skc_pkg::tab_req_t            req,
  output logic [skc_pkg::WORD_W-1:0]   rd_a,
  output logic [skc_pkg::WORD_W-1:0]   rd_b
);
  import skc_pkg::*;

  logic [WORD_W-1:0] mem [0:TABLE_LEN-1];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_a <= mem[req.rd_addr_a];
      rd_b <= mem[req.rd_addr_b];
    end
  end

endmodule

/* hw/rtl/skc_alu.sv */
// shared arithmetic unit: modulo 2^32 subtract for fill and mixing, xor for crypt
// depends on skc_pkg

module skc_alu (
  input  skc_pkg::alu_op_t             op,
  input  logic [skc_pkg::WORD_W-1:0]   a,
  input  logic [skc_pkg::WORD_W-1:0]   b,
  output logic [skc_pkg::WORD_W-1:0]   y
);
  import skc_pkg::*;

  always_comb begin
    unique case (op)
      ALU_SUB: y = a - b;
      ALU_XOR: y = a ^ b;
    endcase
  end

endmodule

/* hw/rtl/subtractive_keystream_xor_cipher_unit.sv */
// subtractive keystream xor cipher, top level: sequencer, key table, shared alu
// crypt word: a read state, then a write state that xors and registers the result; the write
// state waits while an earlier result is still held, and a word that finds the table used up
// first runs one mixing pass of 55 read/write steps; rekey word: 55 fill writes, then 4 mixing
// passes of 55 read/write steps; the table port and single alu are shared, one word at a time
// sync reset: read position 56, sequencer idle, no result held; table undefined

module subtractive_keystream_xor_cipher_unit (
  input logic        clk,
  input logic        rst,
  skc_stream_if.sink   cmd,
  skc_stream_if.source rsp
);
  import skc_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_FILL     = 3'd1;
  localparam logic [2:0] ST_MIX_RD   = 3'd2;
  localparam logic [2:0] ST_MIX_WR   = 3'd3;
  localparam logic [2:0] ST_CRYPT_RD = 3'd4;
  localparam logic [2:0] ST_CRYPT_WR = 3'd5;

  logic [2:0]        state;
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] step;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] fill_cnt;
  logic [1:0]        pass;
  logic              rekey;
  logic [WORD_W-1:0] prev;
  logic [WORD_W-1:0] cur;
  logic [WORD_W-1:0] word_reg;
  logic              last_reg;
  logic              rsp_valid;
  rsp_item_t         rsp_data;

  tab_req_t          tab_req;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  alu_op_t           alu_op;
  logic [WORD_W-1:0] alu_a;
  logic [WORD_W-1:0] alu_b;
  logic [WORD_W-1:0] alu_y;
  logic [ADDR_W:0]   slot_sum;
  logic [ADDR_W-1:0] slot_next;
  logic              pos_spent;

  skc_table u_table (
    .clk  (clk),
    .req  (tab_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  skc_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign slot_sum  = {1'b0, slot} + (ADDR_W+1)'(FILL_STEP);
  assign slot_next = (slot_sum >= (ADDR_W+1)'(TABLE_LEN)) ?
                     ADDR_W'(slot_sum - (ADDR_W+1)'(TABLE_LEN)) : slot_sum[ADDR_W-1:0];
  assign pos_spent = (pos == '0) || (pos >= POS_W'(POS_EMPTY));

  // table port and alu operand selection
  always_comb begin
    tab_req = '0;
    alu_op  = ALU_SUB;
    alu_a   = rd_a;
    alu_b   = rd_b;
    unique case (state)
      ST_FILL: begin
        alu_a           = prev;
        alu_b           = cur;
        tab_req.wr_en   = 1'b1;
        if (fill_cnt == '0) begin
          tab_req.wr_addr = ADDR_W'(TABLE_LEN - 1);
          tab_req.wr_data = prev;
        end else begin
          tab_req.wr_addr = slot - ADDR_W'(1);
          tab_req.wr_data = cur;
        end
      end
      ST_MIX_RD: begin
        tab_req.rd_en     = 1'b1;
        tab_req.rd_addr_a = step - ADDR_W'(1);
        if (step <= ADDR_W'(MIX_LOW_COUNT)) begin
          tab_req.rd_addr_b = step + ADDR_W'(MIX_LOW_OFFSET - 1);
        end else begin
          tab_req.rd_addr_b = step - ADDR_W'(MIX_HIGH_OFFSET + 1);
        end
      end
      ST_MIX_WR: begin
        tab_req.wr_en   = 1'b1;
        tab_req.wr_addr = step - ADDR_W'(1);
        tab_req.wr_data = alu_y;
      end
      ST_CRYPT_RD: begin
        tab_req.rd_en     = 1'b1;
        tab_req.rd_addr_a = ADDR_W'(pos - POS_W'(1));
        tab_req.rd_addr_b = ADDR_W'(pos - POS_W'(1));
      end
      ST_CRYPT_WR: begin
        alu_op = ALU_XOR;
        alu_a  = word_reg;
        alu_b  = rd_a;
      end
      default: begin
        tab_req = '0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= POS_W'(POS_EMPTY);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && (state != ST_CRYPT_WR)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            word_reg <= cmd.data.word;
            last_reg <= cmd.data.last_word;
            if (cmd.data.mode == MODE_REKEY) begin
              prev     <= cmd.data.seed;
              cur      <= WORD_W'(1);
              slot     <= ADDR_W'(FILL_STEP);
              fill_cnt <= '0;
              rekey    <= 1'b1;
              state    <= ST_FILL;
            end else if (pos_spent) begin
              step  <= ADDR_W'(1);
              rekey <= 1'b0;
              state <= ST_MIX_RD;
            end else begin
              state <= ST_CRYPT_RD;
            end
          end
        end
        ST_FILL: begin
          if (fill_cnt != '0) begin
            prev <= cur;
            cur  <= alu_y;
            slot <= slot_next;
          end
          fill_cnt <= fill_cnt + ADDR_W'(1);
          if (fill_cnt == ADDR_W'(FILL_STEPS)) begin
            step  <= ADDR_W'(1);
            pass  <= '0;
            state <= ST_MIX_RD;
          end
        end
        ST_MIX_RD: begin
          state <= ST_MIX_WR;
        end
        ST_MIX_WR: begin
          if (step == ADDR_W'(TABLE_LEN)) begin
            if (!rekey) begin
              pos   <= POS_W'(1);
              state <= ST_CRYPT_RD;
            end else if (pass == 2'(MIX_PASSES - 1)) begin
              pos   <= POS_W'(POS_EMPTY);
              state <= ST_IDLE;
            end else begin
              pass  <= pass + 2'd1;
              step  <= ADDR_W'(1);
              state <= ST_MIX_RD;
            end
          end else begin
            step  <= step + ADDR_W'(1);
            state <= ST_MIX_RD;
          end
        end
        ST_CRYPT_RD: begin
          state <= ST_CRYPT_WR;
        end
        ST_CRYPT_WR: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid         <= 1'b1;
            rsp_data.out_word <= alu_y;
            rsp_data.out_last <= last_reg;
            pos               <= pos + POS_W'(1);
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_CRYPT_WR)
    else $error("result raised outside the crypt write step");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_CRYPT_RD |-> pos >= POS_W'(1) && pos <= POS_W'(TABLE_LEN))
    else $error("crypt read position outside the table");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_FILL && fill_cnt != '0 |->
      slot != '0 && slot < ADDR_W'(TABLE_LEN))
    else $error("fill slot outside 1 to 54");

  assert property (@(posedge clk) disable iff (rst)
    state == ST_MIX_WR |-> $past(state) == ST_MIX_RD && $stable(step))
    else $error("mixing write without its read step");

endmodule

/* tb/subtractive_keystream_xor_cipher_unit_test.sv */
// self-checking testbench for subtractive_keystream_xor_cipher_unit: rekeys and crypt words
// go in on the cmd stream, and each crypt result is compared with an in-bench keystream model
// depends on skc_pkg, skc_stream_if and the cipher unit rtl
`timescale 1ns / 1ps

module subtractive_keystream_xor_cipher_unit_test;
  import skc_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned PHASE_WORDS = 600;

  logic clk;
  logic rst;

  skc_stream_if #(.payload_t(cmd_item_t)) cmd_ch ();
  skc_stream_if #(.payload_t(rsp_item_t)) rsp_ch ();

  subtractive_keystream_xor_cipher_unit DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  logic [WORD_W-1:0] key_words [1:TABLE_LEN];
  int unsigned key_pos;
  rsp_item_t pending_cipher [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned cmd_gap_pct;
  int unsigned rsp_stall_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void stir_table();
    int unsigned i;
    for (i = 1; i <= MIX_LOW_COUNT; i++) begin
      key_words[i] = key_words[i] - key_words[i + MIX_LOW_OFFSET];
    end
    for (i = MIX_LOW_COUNT + 1; i <= TABLE_LEN; i++) begin
      key_words[i] = key_words[i] - key_words[i - MIX_HIGH_OFFSET];
    end
  endfunction

  function automatic void load_seed(input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] nxt;
    int unsigned n;
    key_words[TABLE_LEN] = seed;
    prev = seed;
    cur = 1;
    for (n = FILL_STEP; n <= FILL_END; n += FILL_STEP) begin
      nxt = prev - cur;
      key_words[n % TABLE_LEN] = cur;
      prev = cur;
      cur = nxt;
    end
    repeat (MIX_PASSES) stir_table();
    key_pos = POS_EMPTY;
  endfunction

  function automatic logic [WORD_W-1:0] next_key_word();
    logic [WORD_W-1:0] ks;
    if (key_pos == 0 || key_pos >= POS_EMPTY) begin
      stir_table();
      key_pos = 1;
    end
    ks = key_words[key_pos];
    key_pos++;
    return ks;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word32();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(input logic mode, input logic [WORD_W-1:0] seed,
                           input logic [WORD_W-1:0] word, input logic last);
    while ($urandom_range(0, 99) < cmd_gap_pct) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= cmd_item_t'{mode: mode, seed: seed, word: word, last_word: last};
    do @(posedge clk); while (!cmd_ch.ready);
    if (mode == MODE_CRYPT) begin
      pending_cipher.push_back(rsp_item_t'{out_word: word ^ next_key_word(), out_last: last});
    end else begin
      load_seed(seed);
    end
  endtask

  task automatic test_seed_extremes();
    // ignored fields carry extreme values
    send_item(MODE_REKEY, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_CRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_item(MODE_CRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_item(MODE_REKEY, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_item(MODE_CRYPT, 32'h0000_0000, 32'hA5A5_5A5A, 1'b0);
    send_item(MODE_CRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_rekey_midstream();
    int unsigned k;
    send_item(MODE_REKEY, 32'h0000_0001, $urandom, 1'b0);
    for (k = 0; k < 3; k++) send_item(MODE_CRYPT, $urandom, $urandom, 1'b0);
    // same seed again restarts the keystream
    send_item(MODE_REKEY, 32'h0000_0001, $urandom, 1'b1);
    for (k = 0; k < 3; k++) send_item(MODE_CRYPT, $urandom, $urandom, k == 2);
  endtask

  task automatic test_single_word_buffers();
    send_item(MODE_REKEY, 32'h8000_0001, 32'h0, 1'b0);
    repeat (4) send_item(MODE_CRYPT, $urandom, $urandom, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned run_len;
    int unsigned k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) != 0) begin
        send_item(MODE_REKEY, rand_word32(), $urandom, 1'($urandom_range(0, 1)));
        sent++;
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(40, 170);
        for (k = 0; k < run_len; k++) begin
          send_item(MODE_CRYPT, $urandom, rand_word32(),
                    (k == run_len - 1) || ($urandom_range(0, 7) == 0));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_item(($urandom_range(0, 3) == 0) ? MODE_REKEY : MODE_CRYPT, rand_word32(),
                    rand_word32(), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin : check_results
    rsp_item_t got;
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (pending_cipher.size() == 0) begin
        report_mismatch("unexpected word", got.out_word, '0);
      end else begin
        want = pending_cipher.pop_front();
        if (got.out_word !== want.out_word) begin
          report_mismatch("out_word", got.out_word, want.out_word);
        end
        if (got.out_last !== want.out_last) begin
          report_mismatch("out_last", WORD_W'(got.out_last), WORD_W'(want.out_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    rsp_ch.ready = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;
    key_pos = POS_EMPTY;
    cmd_gap_pct = 25;
    rsp_stall_pct = 87;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_seed_extremes();
    test_rekey_midstream();
    test_single_word_buffers();
    test_random_traffic(PHASE_WORDS);
    cmd_gap_pct = 87;
    rsp_stall_pct = 25;
    test_random_traffic(PHASE_WORDS);
    cmd_gap_pct = 0;
    rsp_stall_pct = 0;
    test_random_traffic(PHASE_WORDS);

    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* subtractive_keystream_xor_cipher_unit.f */
hw/rtl/skc_pkg.sv
hw/rtl/skc_stream_if.sv
hw/rtl/skc_table.sv
hw/rtl/skc_alu.sv
hw/rtl/subtractive_keystream_xor_cipher_unit.sv
tb/subtractive_keystream_xor_cipher_unit_test.sv
